[src/assert_macros.svh]
// Assertion macros used by the RTL of the aim target jump filter.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every clock edge out of reset.
`define AJF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds on a clock edge out of reset.
`define AJF_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[src/ajf_pkg.sv]
// Package for the aim target jump filter: fixed point constants, register
// reset values, configuration indexes and small helpers. No dependencies.
`timescale 1ns / 1ps

package ajf_pkg;

  // Fraction bits of all angles, rates and angle limits
  localparam int FRAC_BITS = 16;

  // 180/pi in signed Q7.24 (31 bits) and the rounding offset for the shift back
  localparam int                 RAD_SHIFT     = 24;
  localparam logic signed [30:0] DEG_PER_RAD   = 31'sd961263669;
  localparam int                 PROD_W        = 63;
  localparam logic signed [62:0] ROUND_HALF    = 63'sd1 <<< (RAD_SHIFT - 1);

  // Width of the yaw error path, with headroom for the fold and the offset
  localparam int                 ERR_W         = 42;
  localparam logic signed [41:0] HALF_TURN     = 42'(64'sd180 <<< FRAC_BITS);
  localparam logic signed [41:0] FULL_TURN     = 42'(64'sd360 <<< FRAC_BITS);
  localparam logic signed [41:0] S32_MAX       = 42'sd2147483647;
  localparam logic signed [41:0] S32_MIN       = -42'sd2147483648;

  // Register reset values
  localparam logic [30:0] YAW_LIM_RST   = 31'(64'd12 << FRAC_BITS);
  localparam logic [30:0] PITCH_LIM_RST = 31'(((64'd26 << FRAC_BITS) + 64'd50) / 64'd100);
  localparam logic [15:0] REJ_LIM_RST   = 16'd50;
  localparam logic [15:0] ZERO_LIM_RST  = 16'd10;
  localparam logic [7:0]  NCC_RST       = 8'd0;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_YAW_LIM   = 3'd0,
    CFG_PITCH_LIM = 3'd1,
    CFG_REJ_LIM   = 3'd2,
    CFG_ZERO_LIM  = 3'd3,
    CFG_NCC       = 3'd4
  } cfg_idx_e;

  // Saturating 16-bit increment
  function automatic logic [15:0] sat_inc16(input logic [15:0] c);
    sat_inc16 = (c == 16'hFFFF) ? c : c + 16'd1;
  endfunction

endpackage

[src/aim_target_jump_filter.sv]
// Top level of the aim target jump filter: pipelined yaw conversion and the
// jump test against the held target. Depends on ajf_pkg and assert_macros.svh.
`timescale 1ns / 1ps
//
//  channel | signals                          | direction | accepted when
//  --------+----------------------------------+-----------+---------------------------
//  in      | in_valid_i, in_stall_o, fields   | into      | in_valid_i && !in_stall_o
//  out     | out_valid_o, out_stall_i, fields | out of    | out_valid_o && !out_stall_i
//  cfg     | cfg_we_i, cfg_idx_i, cfg_wdata_i | into      | cfg_we_i
//
//  One request per cycle while results are not stalled; each request passes through the
//  input register, the 32x31 multiply by 180/pi, fold and saturate, then the jump test.
//  The rate is set by the last stage, which reads and updates the held state as it loads.
//  Reset clears the pipeline, counters and held targets and loads the register defaults.
//  A stalled result holds all stages behind it; the input stalls only when full.

module aim_target_jump_filter (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [30:0]        cfg_wdata_i,
  // input frames
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         req_mode_i,
  input  logic signed [31:0] target_yaw_i,
  input  logic signed [31:0] target_pitch_i,
  input  logic signed [31:0] yaw_rate_i,
  input  logic signed [31:0] pitch_rate_i,
  input  logic signed [31:0] yaw_accel_i,
  input  logic signed [31:0] pitch_accel_i,
  input  logic signed [31:0] imu_yaw_i,
  input  logic signed [31:0] gimbal_yaw_now_i,
  // results
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         ctrl_mode_o,
  output logic signed [31:0] aim_yaw_o,
  output logic signed [31:0] aim_pitch_o,
  output logic signed [31:0] ff_yaw_rate_o,
  output logic signed [31:0] ff_pitch_rate_o,
  output logic signed [31:0] ff_yaw_accel_o,
  output logic signed [31:0] ff_pitch_accel_o,
  output logic               target_taken_o
);

  `include "assert_macros.svh"

  // Payload carried down the pipeline
  typedef struct packed {
    logic [7:0]         mode;
    logic signed [31:0] pitch;
    logic signed [31:0] yaw_rate;
    logic signed [31:0] pitch_rate;
    logic signed [31:0] yaw_accel;
    logic signed [31:0] pitch_accel;
    logic               zero;
  } frame_t;

  // Configuration registers
  logic [30:0] yaw_lim_q, pitch_lim_q;
  logic [15:0] rej_lim_q, zero_lim_q;
  logic [7:0]  ncc_q;

  // Pipeline registers
  logic               s1_vld_q, s2_vld_q, s3_vld_q, out_vld_q;
  frame_t             s1_frm_q, s2_frm_q, s3_frm_q;
  logic signed [31:0] s1_tyaw_q, s1_imu_q, s1_gnow_q;
  logic signed [31:0] s2_imu_q, s2_gnow_q;
  logic signed [62:0] s2_prod_q;
  logic signed [31:0] s3_yaw_q;

  // Filter state
  logic signed [31:0] last_yaw_q, last_pitch_q, held_yaw_q, held_pitch_q;
  logic signed [31:0] held_ff_q [4];
  logic               tgt_vld_q;
  logic [15:0]        reject_q, zero_run_q;
  logic [7:0]         mode_q;
  logic               taken_q;

  // Flow control: each stage moves when the one ahead has room
  logic out_free, s3_go, s3_free, s2_go, s2_free, s1_go, s1_free, in_go;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign s3_go      = s3_vld_q && out_free;
  assign s3_free    = !s3_vld_q || out_free;
  assign s2_go      = s2_vld_q && s3_free;
  assign s2_free    = !s2_vld_q || s3_free;
  assign s1_go      = s1_vld_q && s2_free;
  assign s1_free    = !s1_vld_q || s2_free;
  assign in_stall_o = !s1_free;
  assign in_go      = in_valid_i && s1_free;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yaw_lim_q   <= ajf_pkg::YAW_LIM_RST;
      pitch_lim_q <= ajf_pkg::PITCH_LIM_RST;
      rej_lim_q   <= ajf_pkg::REJ_LIM_RST;
      zero_lim_q  <= ajf_pkg::ZERO_LIM_RST;
      ncc_q       <= ajf_pkg::NCC_RST;
    end else if (cfg_we_i) begin
      unique case (ajf_pkg::cfg_idx_e'(cfg_idx_i))
        ajf_pkg::CFG_YAW_LIM:   yaw_lim_q   <= cfg_wdata_i;
        ajf_pkg::CFG_PITCH_LIM: pitch_lim_q <= cfg_wdata_i;
        ajf_pkg::CFG_REJ_LIM:   rej_lim_q   <= cfg_wdata_i[15:0];
        ajf_pkg::CFG_ZERO_LIM:  zero_lim_q  <= cfg_wdata_i[15:0];
        ajf_pkg::CFG_NCC:       ncc_q       <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Valid bits of the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s1_free)  s1_vld_q  <= in_valid_i;
      if (s2_free)  s2_vld_q  <= s1_vld_q;
      if (s3_free)  s3_vld_q  <= s2_vld_q;
      if (out_free) out_vld_q <= s3_vld_q;
    end
  end

  // Stage 1: register the request
  always_ff @(posedge clk_i) begin
    if (in_go) begin
      s1_frm_q.mode        <= req_mode_i;
      s1_frm_q.pitch       <= target_pitch_i;
      s1_frm_q.yaw_rate    <= yaw_rate_i;
      s1_frm_q.pitch_rate  <= pitch_rate_i;
      s1_frm_q.yaw_accel   <= yaw_accel_i;
      s1_frm_q.pitch_accel <= pitch_accel_i;
      s1_frm_q.zero        <= (target_yaw_i == 32'sd0) && (target_pitch_i == 32'sd0);
      s1_tyaw_q            <= target_yaw_i;
      s1_imu_q             <= imu_yaw_i;
      s1_gnow_q            <= gimbal_yaw_now_i;
    end
  end

  // Stage 2: scale the yaw target by 180/pi
  logic signed [62:0] prod_d;
  assign prod_d = s1_tyaw_q * ajf_pkg::DEG_PER_RAD;

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      s2_frm_q  <= s1_frm_q;
      s2_prod_q <= prod_d;
      s2_imu_q  <= s1_imu_q;
      s2_gnow_q <= s1_gnow_q;
    end
  end

  // Stage 3: round to degrees, fold the error once, add to the gimbal position, saturate
  logic signed [62:0] rnd;
  logic signed [41:0] deg, err, err_hi, err_f, yaw_sum;
  logic signed [31:0] yaw_d;

  always_comb begin
    rnd    = s2_prod_q + ajf_pkg::ROUND_HALF;
    deg    = ajf_pkg::ERR_W'($signed(rnd[ajf_pkg::PROD_W-1:ajf_pkg::RAD_SHIFT]));
    err    = deg - ajf_pkg::ERR_W'(s2_imu_q);
    err_hi = (err > ajf_pkg::HALF_TURN) ? err - ajf_pkg::FULL_TURN : err;
    err_f  = (err_hi < -ajf_pkg::HALF_TURN) ? err_hi + ajf_pkg::FULL_TURN : err_hi;
    yaw_sum = ajf_pkg::ERR_W'(s2_gnow_q) + err_f;
    priority if (yaw_sum > ajf_pkg::S32_MAX) begin
      yaw_d = 32'sh7FFFFFFF;
    end else if (yaw_sum < ajf_pkg::S32_MIN) begin
      yaw_d = 32'sh80000000;
    end else begin
      yaw_d = yaw_sum[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_go) begin
      s3_frm_q <= s2_frm_q;
      s3_yaw_q <= yaw_d;
    end
  end

  // Stage 4: zero-frame timeout, mode and jump test against the held state
  logic [15:0]        zero_run_d, reject_d;
  logic [7:0]         mode_d;
  logic               no_ctrl, take_d, tgt_vld_d;
  logic signed [31:0] ref_yaw, ref_pitch;
  logic signed [32:0] dy, dp;
  logic [32:0]        mag_y, mag_p;
  logic               jump_ok;

  always_comb begin
    zero_run_d = s3_frm_q.zero ? ajf_pkg::sat_inc16(zero_run_q) : 16'd0;
    mode_d     = (s3_frm_q.zero && (zero_run_d >= zero_lim_q)) ? ncc_q : s3_frm_q.mode;
    no_ctrl    = (mode_d == ncc_q);

    // First target after a reset or no-control is its own reference
    ref_yaw   = tgt_vld_q ? last_yaw_q   : s3_yaw_q;
    ref_pitch = tgt_vld_q ? last_pitch_q : s3_frm_q.pitch;
    dy        = 33'(s3_yaw_q) - 33'(ref_yaw);
    dp        = 33'(s3_frm_q.pitch) - 33'(ref_pitch);
    mag_y     = dy[32] ? 33'(-dy) : 33'(dy);
    mag_p     = dp[32] ? 33'(-dp) : 33'(dp);
    jump_ok   = (mag_y <= {2'b00, yaw_lim_q}) && (mag_p <= {2'b00, pitch_lim_q});

    take_d    = 1'b0;
    tgt_vld_d = tgt_vld_q;
    reject_d  = reject_q;
    priority if (no_ctrl) begin
      tgt_vld_d = 1'b0;
      reject_d  = 16'd0;
    end else if (s3_frm_q.zero) begin
      reject_d  = ajf_pkg::sat_inc16(reject_q);
    end else begin
      tgt_vld_d = 1'b1;
      take_d    = jump_ok || (reject_q >= rej_lim_q);
      reject_d  = take_d ? 16'd0 : ajf_pkg::sat_inc16(reject_q);
    end
  end

  // Update state and result flags as the result is loaded
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_yaw_q   <= '0;
      last_pitch_q <= '0;
      held_yaw_q   <= '0;
      held_pitch_q <= '0;
      held_ff_q    <= '{default: '0};
      tgt_vld_q    <= 1'b0;
      reject_q     <= '0;
      zero_run_q   <= '0;
      mode_q       <= '0;
      taken_q      <= 1'b0;
    end else if (s3_go) begin
      zero_run_q <= zero_run_d;
      reject_q   <= reject_d;
      tgt_vld_q  <= tgt_vld_d;
      mode_q     <= mode_d;
      taken_q    <= take_d;
      if (take_d) begin
        last_yaw_q   <= s3_yaw_q;
        last_pitch_q <= s3_frm_q.pitch;
        held_yaw_q   <= s3_yaw_q;
        held_pitch_q <= s3_frm_q.pitch;
        held_ff_q[0] <= s3_frm_q.yaw_rate;
        held_ff_q[1] <= s3_frm_q.pitch_rate;
        held_ff_q[2] <= s3_frm_q.yaw_accel;
        held_ff_q[3] <= s3_frm_q.pitch_accel;
      end
    end
  end

  // Drive the result; held values only change when a new result loads
  assign out_valid_o      = out_vld_q;
  assign ctrl_mode_o      = mode_q;
  assign target_taken_o   = taken_q;
  assign aim_yaw_o        = held_yaw_q;
  assign aim_pitch_o      = held_pitch_q;
  assign ff_yaw_rate_o    = held_ff_q[0];
  assign ff_pitch_rate_o  = held_ff_q[1];
  assign ff_yaw_accel_o   = held_ff_q[2];
  assign ff_pitch_accel_o = held_ff_q[3];

  // A taken target clears the rejection run
  `AJF_ASSERT(a_take_clears_reject, (s3_go && take_d) |=> (reject_q == 16'd0), "reject run not cleared")
  // A taken result leaves a valid reference behind it
  `AJF_ASSERT_NEVER(a_taken_ref_valid, out_vld_q && taken_q && !tgt_vld_q, "reference lost")
  // The reference follows the held target after a take
  `AJF_ASSERT(a_taken_ref_match, (out_vld_q && taken_q) |-> (last_yaw_q == held_yaw_q), "reference mismatch")

endmodule

[tb/tb_aim_target_jump_filter.sv]
// Self-checking testbench for aim_target_jump_filter: a clocked driver and monitor
// around the block, with a bit-exact predictor of the jump filter in the bench.
// Depends on ajf_pkg and the RTL of aim_target_jump_filter.
`timescale 1ns / 1ps

module tb_aim_target_jump_filter;

  // Fixed point constants of the filter, Q16.16 unless noted
  localparam longint DEG_RAD_Q24 = 64'sd961263669;
  localparam longint ROUND_Q24   = 64'sd1 <<< 23;
  localparam longint HALF_TURN_Q = 64'sd180 * 64'sd65536;
  localparam longint FULL_TURN_Q = 64'sd360 * 64'sd65536;
  localparam longint S32_HI      = 64'sd2147483647;
  localparam longint S32_LO      = -64'sd2147483648;
  localparam int     SETTLE_CYC  = 8;
  localparam int     HOLD_CYC    = 100;

  typedef struct packed {
    logic [7:0]  mode;
    logic [31:0] tyaw;
    logic [31:0] tpitch;
    logic [31:0] yrate;
    logic [31:0] prate;
    logic [31:0] yacc;
    logic [31:0] pacc;
    logic [31:0] imu;
    logic [31:0] gyaw;
  } frame_t;

  typedef struct packed {
    logic [7:0]  mode;
    logic [31:0] yaw;
    logic [31:0] pitch;
    logic [31:0] yrate;
    logic [31:0] prate;
    logic [31:0] yacc;
    logic [31:0] pacc;
    logic        taken;
  } aim_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  logic        cfg_we_i    = 1'b0;
  logic [2:0]  cfg_idx_i   = 3'd0;
  logic [30:0] cfg_wdata_i = 31'd0;

  logic        in_valid_i       = 1'b0;
  logic        in_stall_o;
  logic [7:0]  req_mode_i       = 8'd0;
  logic [31:0] target_yaw_i     = 32'd0;
  logic [31:0] target_pitch_i   = 32'd0;
  logic [31:0] yaw_rate_i       = 32'd0;
  logic [31:0] pitch_rate_i     = 32'd0;
  logic [31:0] yaw_accel_i      = 32'd0;
  logic [31:0] pitch_accel_i    = 32'd0;
  logic [31:0] imu_yaw_i        = 32'd0;
  logic [31:0] gimbal_yaw_now_i = 32'd0;

  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  ctrl_mode_o;
  logic [31:0] aim_yaw_o;
  logic [31:0] aim_pitch_o;
  logic [31:0] ff_yaw_rate_o;
  logic [31:0] ff_pitch_rate_o;
  logic [31:0] ff_yaw_accel_o;
  logic [31:0] ff_pitch_accel_o;
  logic        target_taken_o;

  aim_target_jump_filter dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_mode_i       (req_mode_i),
    .target_yaw_i     (target_yaw_i),
    .target_pitch_i   (target_pitch_i),
    .yaw_rate_i       (yaw_rate_i),
    .pitch_rate_i     (pitch_rate_i),
    .yaw_accel_i      (yaw_accel_i),
    .pitch_accel_i    (pitch_accel_i),
    .imu_yaw_i        (imu_yaw_i),
    .gimbal_yaw_now_i (gimbal_yaw_now_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .ctrl_mode_o      (ctrl_mode_o),
    .aim_yaw_o        (aim_yaw_o),
    .aim_pitch_o      (aim_pitch_o),
    .ff_yaw_rate_o    (ff_yaw_rate_o),
    .ff_pitch_rate_o  (ff_pitch_rate_o),
    .ff_yaw_accel_o   (ff_yaw_accel_o),
    .ff_pitch_accel_o (ff_pitch_accel_o),
    .target_taken_o   (target_taken_o)
  );

  // Register copies, loaded with the reset defaults
  logic [30:0] lim_yaw    = 31'(12 * 65536);
  logic [30:0] lim_pitch  = 31'((26 * 65536 + 50) / 100);
  logic [15:0] lim_reject = 16'd50;
  logic [15:0] lim_zero   = 16'd10;
  logic [7:0]  code_idle  = 8'd0;

  // Filter state
  longint      track_yaw   = 0;
  longint      track_pitch = 0;
  logic        track_set   = 1'b0;
  logic [15:0] reject_cnt  = 16'd0;
  logic [15:0] zero_cnt    = 16'd0;
  logic [31:0] kept_yaw    = 32'd0;
  logic [31:0] kept_pitch  = 32'd0;
  logic [31:0] kept_yrate  = 32'd0;
  logic [31:0] kept_prate  = 32'd0;
  logic [31:0] kept_yacc   = 32'd0;
  logic [31:0] kept_pacc   = 32'd0;

  frame_t frame_q[$];
  aim_t   aim_due_q[$];
  frame_t cur_frame;
  logic   offering  = 1'b0;
  int     gap_left  = 0;
  int     stall_left = 0;
  int     hold_left = 0;
  int     hold_asks = 0;
  int     holds_done = 0;
  int     in_gap_pct = 0;
  int     out_stall_pct = 0;
  int     fail_cnt  = 0;

  // Run one frame through the filter state and return the result it causes
  function automatic aim_t filter_frame(input frame_t f);
    aim_t   r;
    logic [7:0] mode;
    logic   zero_f;
    logic   hit;
    longint deg;
    longint err;
    longint cand_yaw;
    longint cand_pitch;
    longint dy;
    longint dp;
    mode = f.mode;
    zero_f = (f.tyaw == 32'd0) && (f.tpitch == 32'd0);
    hit = 1'b0;
    if (zero_f) begin
      if (zero_cnt != 16'hFFFF) zero_cnt = zero_cnt + 16'd1;
      if (zero_cnt >= lim_zero) mode = code_idle;
    end else begin
      zero_cnt = 16'd0;
    end
    if (mode != code_idle) begin
      if (!zero_f) begin
        // radians to degrees, round half up, then fold the error once
        deg = (longint'($signed(f.tyaw)) * DEG_RAD_Q24 + ROUND_Q24) >>> 24;
        err = deg - longint'($signed(f.imu));
        if (err > HALF_TURN_Q) err = err - FULL_TURN_Q;
        if (err < -HALF_TURN_Q) err = err + FULL_TURN_Q;
        cand_yaw = longint'($signed(f.gyaw)) + err;
        if (cand_yaw > S32_HI) cand_yaw = S32_HI;
        else if (cand_yaw < S32_LO) cand_yaw = S32_LO;
        cand_pitch = longint'($signed(f.tpitch));
        if (!track_set) begin
          track_yaw = cand_yaw;
          track_pitch = cand_pitch;
          track_set = 1'b1;
        end
        dy = cand_yaw - track_yaw;
        dp = cand_pitch - track_pitch;
        if (dy < 0) dy = -dy;
        if (dp < 0) dp = -dp;
        if ((dy <= longint'(lim_yaw) && dp <= longint'(lim_pitch)) ||
            reject_cnt >= lim_reject) begin
          kept_yaw = cand_yaw[31:0];
          kept_pitch = f.tpitch;
          kept_yrate = f.yrate;
          kept_prate = f.prate;
          kept_yacc = f.yacc;
          kept_pacc = f.pacc;
          track_yaw = cand_yaw;
          track_pitch = cand_pitch;
          reject_cnt = 16'd0;
          hit = 1'b1;
        end else if (reject_cnt != 16'hFFFF) begin
          reject_cnt = reject_cnt + 16'd1;
        end
      end else if (reject_cnt != 16'hFFFF) begin
        reject_cnt = reject_cnt + 16'd1;
      end
    end else begin
      track_set = 1'b0;
      reject_cnt = 16'd0;
    end
    r.mode = mode;
    r.yaw = kept_yaw;
    r.pitch = kept_pitch;
    r.yrate = kept_yrate;
    r.prate = kept_prate;
    r.yacc = kept_yacc;
    r.pacc = kept_pacc;
    r.taken = hit;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected 0x%h, got 0x%h", name, exp_v, got_v);
      fail_cnt++;
    end
  endfunction

  function automatic int srand(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Frame with the given target and pose, random feed-forward values
  function automatic frame_t mk_frame(input logic [7:0] m, input logic [31:0] ty,
                                      input logic [31:0] tp, input logic [31:0] imu,
                                      input logic [31:0] gy);
    frame_t f;
    f.mode = m;
    f.tyaw = ty;
    f.tpitch = tp;
    f.yrate = $urandom;
    f.prate = $urandom;
    f.yacc = $urandom;
    f.pacc = $urandom;
    f.imu = imu;
    f.gyaw = gy;
    return f;
  endfunction

  function automatic int pick_len(input int pct);
    if (int'($urandom_range(0, 99)) >= pct) return 0;
    if ($urandom_range(0, 9) < 8) return int'($urandom_range(1, 3));
    return int'($urandom_range(10, 40));
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Drive requests from the pending queue, with random gaps
  always @(negedge clk_i) begin
    if (!offering) begin
      if (in_valid_i) gap_left = pick_len(in_gap_pct);
      if (gap_left > 0 || frame_q.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_valid_i <= 1'b0;
      end else begin
        cur_frame = frame_q.pop_front();
        req_mode_i <= cur_frame.mode;
        target_yaw_i <= cur_frame.tyaw;
        target_pitch_i <= cur_frame.tpitch;
        yaw_rate_i <= cur_frame.yrate;
        pitch_rate_i <= cur_frame.prate;
        yaw_accel_i <= cur_frame.yacc;
        pitch_accel_i <= cur_frame.pacc;
        imu_yaw_i <= cur_frame.imu;
        gimbal_yaw_now_i <= cur_frame.gyaw;
        in_valid_i <= 1'b1;
        offering = 1'b1;
      end
    end
  end

  // Predict the result of every accepted request
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      aim_due_q.push_back(filter_frame(cur_frame));
      offering = 1'b0;
    end
  end

  // Stall results at random; hold off for a long stretch when asked
  always @(negedge clk_i) begin
    if (hold_asks != holds_done) begin
      hold_left = HOLD_CYC;
      holds_done++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else begin
      stall_left = pick_len(out_stall_pct);
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    aim_t due;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (aim_due_q.size() == 0) begin
        $error("result with no request outstanding");
        fail_cnt++;
      end else begin
        due = aim_due_q.pop_front();
        check_field("ctrl_mode", 32'(due.mode), 32'(ctrl_mode_o));
        check_field("aim_yaw", due.yaw, aim_yaw_o);
        check_field("aim_pitch", due.pitch, aim_pitch_o);
        check_field("ff_yaw_rate", due.yrate, ff_yaw_rate_o);
        check_field("ff_pitch_rate", due.prate, ff_pitch_rate_o);
        check_field("ff_yaw_accel", due.yacc, ff_yaw_accel_o);
        check_field("ff_pitch_accel", due.pacc, ff_pitch_accel_o);
        check_field("target_taken", 32'(due.taken), 32'(target_taken_o));
      end
    end
  end

  // Write one register and mirror it in the predictor
  task automatic write_reg(input ajf_pkg::cfg_idx_e idx, input logic [30:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    unique case (idx)
      ajf_pkg::CFG_YAW_LIM:   lim_yaw = val;
      ajf_pkg::CFG_PITCH_LIM: lim_pitch = val;
      ajf_pkg::CFG_REJ_LIM:   lim_reject = val[15:0];
      ajf_pkg::CFG_ZERO_LIM:  lim_zero = val[15:0];
      ajf_pkg::CFG_NCC:       code_idle = val[7:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [30:0] yl, input logic [30:0] pl,
                           input logic [30:0] rl, input logic [30:0] zl,
                           input logic [30:0] nc);
    write_reg(ajf_pkg::CFG_YAW_LIM, yl);
    write_reg(ajf_pkg::CFG_PITCH_LIM, pl);
    write_reg(ajf_pkg::CFG_REJ_LIM, rl);
    write_reg(ajf_pkg::CFG_ZERO_LIM, zl);
    write_reg(ajf_pkg::CFG_NCC, nc);
  endtask

  // Wait until every request is in and every result is out, then settle
  task automatic wait_idle();
    while (frame_q.size() != 0 || offering || aim_due_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // Queue random traffic: mostly smooth tracks, plus zero runs, idle mode and noise
  task automatic queue_frames(input int n);
    int left;
    int run;
    int kind;
    int ty;
    int tp;
    int imu;
    int gy;
    logic [7:0] m;
    left = n;
    while (left > 0) begin
      kind = int'($urandom_range(0, 99));
      m = ($urandom_range(0, 9) == 0) ? code_idle : 8'($urandom);
      if (kind < 60) begin
        run = int'($urandom_range(5, 40));
        ty = srand(262144);
        tp = srand(32768);
        imu = srand(47185920);
        gy = srand(131072000);
        repeat (run) begin
          ty += ($urandom_range(0, 19) == 0) ? srand(131072) : srand(2000);
          tp += ($urandom_range(0, 19) == 0) ? srand(40000) : srand(800);
          imu += srand(20000);
          gy += srand(20000);
          frame_q.push_back(mk_frame(m, ty, tp, imu, gy));
        end
      end else if (kind < 75) begin
        run = int'($urandom_range(1, 14));
        repeat (run) frame_q.push_back(mk_frame(m, 32'd0, 32'd0, $urandom, $urandom));
      end else if (kind < 85) begin
        run = int'($urandom_range(1, 3));
        repeat (run) frame_q.push_back(mk_frame(code_idle, $urandom, $urandom, $urandom,
                                                $urandom));
      end else begin
        run = int'($urandom_range(1, 3));
        repeat (run) frame_q.push_back(mk_frame(8'($urandom), $urandom, $urandom,
                                                $urandom, $urandom));
      end
      left -= run;
    end
  endtask

  initial begin
    frame_t f;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames at reset defaults
    in_gap_pct = 30;
    out_stall_pct = 30;
    frame_q.push_back(mk_frame(8'd1, 32'd0, 32'sd6554, 32'd0, 32'd0));
    frame_q.push_back(mk_frame(8'd1, 32'sd6554, 32'sd6554, 32'd0, 32'd0));
    frame_q.push_back(mk_frame(8'd1, 32'sd65536, 32'sd6554, 32'd0, 32'd0));
    frame_q.push_back(mk_frame(8'd2, 32'sd65536, 32'sd6554, 32'd0, 32'd0));
    // positive saturation as the first target after idle mode
    frame_q.push_back(mk_frame(8'd0, 32'sd65536, 32'sd6554, 32'd0, 32'd0));
    f = mk_frame(8'hFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    f.yrate = 32'h7FFFFFFF;
    f.prate = 32'h7FFFFFFF;
    f.yacc = 32'h7FFFFFFF;
    f.pacc = 32'h7FFFFFFF;
    frame_q.push_back(f);
    // negative saturation
    frame_q.push_back(mk_frame(8'd0, 32'sd65536, 32'sd6554, 32'd0, 32'd0));
    f = mk_frame(8'h80, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
    f.yrate = 32'h80000000;
    f.prate = 32'h80000000;
    f.yacc = 32'h80000000;
    f.pacc = 32'h80000000;
    frame_q.push_back(f);
    // error above +180, below -180, and too large to fold fully
    frame_q.push_back(mk_frame(8'd0, 32'sd65536, 32'sd6554, 32'd0, 32'd0));
    frame_q.push_back(mk_frame(8'd3, 32'sd65536, 32'sd100, -32'sd11141120, 32'd0));
    frame_q.push_back(mk_frame(8'd0, 32'sd65536, 32'sd6554, 32'd0, 32'd0));
    frame_q.push_back(mk_frame(8'd3, -32'sd65536, 32'sd100, 32'sd16384000, 32'd0));
    frame_q.push_back(mk_frame(8'd0, 32'sd65536, 32'sd6554, 32'd0, 32'd0));
    frame_q.push_back(mk_frame(8'd3, 32'sd65536, 32'sd100, -32'sd45875200, 32'd0));
    // zero frames up to and past the timeout
    repeat (11) frame_q.push_back(mk_frame(8'd1, 32'd0, 32'd0, $urandom, $urandom));
    wait_idle();

    // Random traffic at reset defaults
    in_gap_pct = 40;
    out_stall_pct = 40;
    queue_frames(350);
    wait_idle();

    // Lowest limits, every zero frame forces idle mode; no idling
    write_all(31'd0, 31'd0, 31'd0, 31'd0, 31'd255);
    in_gap_pct = 0;
    out_stall_pct = 0;
    queue_frames(250);
    wait_idle();

    // Highest limits; narrow registers get junk in the upper data bits
    write_all(31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h2A5A5A5A);
    in_gap_pct = 20;
    out_stall_pct = 50;
    queue_frames(250);
    wait_idle();

    // Mid settings; hold off results while requests keep coming
    write_all(31'($urandom_range(0, 30 * 65536)), 31'($urandom_range(0, 65536)),
              31'($urandom_range(1, 20)), 31'($urandom_range(1, 20)),
              31'($urandom_range(0, 255)));
    in_gap_pct = 0;
    out_stall_pct = 0;
    queue_frames(300);
    repeat (40) @(posedge clk_i);
    hold_asks++;
    wait_idle();

    // Back to the defaults with heavy idling on both sides
    write_all(31'(12 * 65536), 31'((26 * 65536 + 50) / 100), 31'd50, 31'd10, 31'd0);
    in_gap_pct = 60;
    out_stall_pct = 60;
    queue_frames(550);
    wait_idle();

    if (fail_cnt == 0) begin
      $display("tb_aim_target_jump_filter: PASS");
    end else begin
      $display("tb_aim_target_jump_filter: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #15_000_000;
    $display("tb_aim_target_jump_filter: FAIL");
    $finish;
  end

endmodule
